@@ rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
package sha_pkg;

	typedef enum logic [1:0] {
		MODE_ABSORB        = 2'd0,
		MODE_ABSORB_FINISH = 2'd1,
		MODE_FINISH        = 2'd2,
		MODE_UNUSED        = 2'd3
	} mode_t;

	localparam logic [60:0] LEN_MAX = {61{1'b1}};
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic        start;
		logic [31:0] word;
		logic        word_valid;
	} cmp_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
	} cmp_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

@@ rtl/sha_stream_if.sv @@
`timescale 1ns / 1ps
interface sha_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sha_compress.sv @@
`timescale 1ns / 1ps
// One round per cycle. Message words land in a 16-entry word memory as they
// arrive; a load cycle copies them into a shift window that supplies w[t] and
// extends the schedule once per round. Chain words sit in registers and take
// the working variables in the add cycle after round 63.
module sha_compress (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha_pkg::cmp_req_t    req,
	input  logic                 reinit,
	output sha_pkg::cmp_sts_t    sts,
	output logic [255:0]         chain
);
	import sha_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_LOAD = 4'b0010,
		C_RUN  = 4'b0100,
		C_ADD  = 4'b1000
	} cst_t;

	cst_t state_q;
	logic [31:0] w_mem [16];
	logic [31:0] win_q [16];
	logic [3:0]  wr_ptr_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] hv_q [8];
	logic [31:0] wt, t1, t2, w_new, x, y;

	// message words are written to the word memory; each round writes w[t] back
	always_ff @(posedge clk) begin
		if (req.word_valid) begin
			w_mem[wr_ptr_q] <= req.word;
		end else if (state_q == C_RUN) begin
			w_mem[rnd_q[3:0]] <= wt;
		end
	end

	always_comb begin
		x = win_q[1];
		y = win_q[14];
		w_new = win_q[0] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + win_q[9] +
			(rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
		wt = (rnd_q < 6'd16) ? win_q[0] : w_new;
		t1 = h_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25)) +
			((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd_q] + wt;
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22)) +
			((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= C_IDLE;
			wr_ptr_q <= '0;
			rnd_q    <= '0;
			for (int i = 0; i < 8; i++) hv_q[i] <= INIT_H[i];
		end else begin
			if (req.word_valid) wr_ptr_q <= wr_ptr_q + 4'd1;
			unique case (state_q)
				C_IDLE: begin
					if (reinit) begin
						for (int i = 0; i < 8; i++) hv_q[i] <= INIT_H[i];
					end
					if (req.start) state_q <= C_LOAD;
				end
				C_LOAD: begin
					state_q <= C_RUN;
					rnd_q   <= '0;
				end
				C_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= C_ADD;
				end
				C_ADD: begin
					hv_q[0] <= hv_q[0] + a_q; hv_q[1] <= hv_q[1] + b_q;
					hv_q[2] <= hv_q[2] + c_q; hv_q[3] <= hv_q[3] + d_q;
					hv_q[4] <= hv_q[4] + e_q; hv_q[5] <= hv_q[5] + f_q;
					hv_q[6] <= hv_q[6] + g_q; hv_q[7] <= hv_q[7] + h_q;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// shift window from word memory: rotates w[0..15], then holds w[t-16..t-1]
	always_ff @(posedge clk) begin
		if (state_q == C_LOAD) begin
			for (int i = 0; i < 16; i++) win_q[i] <= w_mem[i];
			a_q <= hv_q[0]; b_q <= hv_q[1]; c_q <= hv_q[2]; d_q <= hv_q[3];
			e_q <= hv_q[4]; f_q <= hv_q[5]; g_q <= hv_q[6]; h_q <= hv_q[7];
		end else if (state_q == C_RUN) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= (rnd_q < 6'd16) ? win_q[0] : w_new;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = (state_q == C_ADD);
	assign chain = {hv_q[0], hv_q[1], hv_q[2], hv_q[3],
		hv_q[4], hv_q[5], hv_q[6], hv_q[7]};
endmodule

@@ rtl/sha256_byte_stream_hasher_top.sv @@
`timescale 1ns / 1ps
// SHA-256 over a byte stream.
// in_ch payload {mode[1:0], data_byte[7:0]}: mode 0 absorbs a byte, 1 absorbs
// and finishes, 2 finishes without a byte, 3 is dropped.
// out_ch payload {digest_part[63:0], part_index[1:0], last_part}: four parts
// per finish, most significant first.
// Bytes are packed into words and written to the round unit's word memory;
// absorbing takes one byte per cycle unless held off. Every 64th byte starts
// a compression (load, 64 rounds, chain add) during which input is held off.
// A finish adds padding bytes at one per cycle, then one or two compressions,
// then the four parts leave on out_ch, one per accepted cycle; a stalled
// receiver holds the current part and the block takes no input meanwhile.
// Reset loads the initial hash values and clears length and fill.
module sha256_byte_stream_hasher_top (
	input  logic         clk,
	input  logic         arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	import sha_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WAIT = 5'b00010,
		S_PAD  = 5'b00100,
		S_PWT  = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	st_t state_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [23:0] acc_q;
	logic        pad_end_q;
	logic [1:0]  part_q;
	logic [63:0] bits;
	cmp_req_t    req;
	cmp_sts_t    sts;
	logic [255:0] chain;
	logic [7:0]  pad_byte;
	logic        reinit;
	logic        in_fire;
	logic [1:0]  mode;
	logic        byte_v;
	logic [7:0]  byte_d;
	logic [7:0]  byte_w;
	logic        first_pad_q;

	sha_compress u_cmp (.clk, .arst_n, .req, .reinit, .sts, .chain);

	assign mode = in_ch.payload[9:8];
	assign in_ch.ready = (state_q == S_IDLE) && !sts.busy;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign bits = {len_q, 3'b000};

	// zero fill, then the big-endian bit length in the last eight bytes
	always_comb begin
		pad_byte = '0;
		if (pad_end_q && fill_q >= LEN_POS)
			pad_byte = bits[8*(63-fill_q) +: 8];
	end

	always_comb begin
		byte_v = 1'b0;
		byte_d = in_ch.payload[7:0];
		if (in_fire && (mode == MODE_ABSORB || mode == MODE_ABSORB_FINISH))
			byte_v = 1'b1;
		if (state_q == S_PAD) begin
			byte_v = 1'b1;
			byte_d = pad_byte;
		end
	end

	// marker byte: first pad cycle writes 0x80 over the zero selection
	assign byte_w = (state_q == S_PAD && first_pad_q) ? PAD_BYTE : byte_d;

	assign req.word_valid = byte_v && (fill_q[1:0] == 2'd3);
	assign req.word = {acc_q, byte_w};
	assign req.start = byte_v && (fill_q == 6'd63);
	assign reinit = (state_q == S_OUT) && out_ch.ready && (part_q == 2'd3);

	// pad_end_q: 0x80 already placed and this block carries the length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			len_q     <= '0;
			pad_end_q <= 1'b0;
			part_q    <= '0;
		end else begin
			if (byte_v) fill_q <= fill_q + 6'd1;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && mode != MODE_UNUSED) begin
						if (mode != MODE_FINISH && len_q != LEN_MAX) len_q <= len_q + 61'd1;
						if (mode != MODE_ABSORB) state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// place the 0x80 marker in the first PAD cycle, with the flag clear
					if (!sts.busy) begin
						state_q   <= S_PAD;
						pad_end_q <= 1'b0;
					end
				end
				S_PAD: begin
					if (!pad_end_q) pad_end_q <= (fill_q < LEN_POS) ? 1'b1 : 1'b0;
					if (fill_q == 6'd63) state_q <= S_PWT;
				end
				S_PWT: begin
					if (sts.done) begin
						if (pad_end_q) begin
							state_q <= S_OUT;
							part_q  <= '0;
						end else begin
							state_q   <= S_PAD;
							pad_end_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						part_q <= part_q + 2'd1;
						if (part_q == 2'd3) begin
							state_q <= S_IDLE;
							len_q   <= '0;
							fill_q  <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_pad_q <= 1'b0;
		else first_pad_q <= (state_q == S_WAIT) && !sts.busy;
	end

	always_ff @(posedge clk) begin
		if (byte_v) acc_q <= {acc_q[15:0], byte_w};
	end

	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.payload = {chain[255 - 64*part_q -: 64], part_q, part_q == 2'd3};
endmodule

@@ rtl/sha_checker.sv @@
`timescale 1ns / 1ps
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [66:0] out_payload
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload)) else $error("part changed");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_payload[0] == (out_payload[2:1] == 2'd3)))
		else $error("last flag");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_payload[0] |=> out_valid &&
		out_payload[2:1] == $past(out_payload[2:1]) + 2'd1) else $error("part order");
endmodule

bind sha256_byte_stream_hasher_top sha_checker u_chk (
	.clk, .arst_n, .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload));
